// ----- rtl/core/mkst_pkg.sv -----
// Shared constants and types for the MIDI key split and transpose block.
package mkst_pkg;

  localparam int KEY_COUNT_DEF = 128;

  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 4;
  localparam int ZCH_W   = 5;
  localparam int SPLIT_W = 8;
  localparam int XPOS_W  = 7;
  localparam int NOTE_W  = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'h7f;
  localparam logic [SPLIT_W-1:0] SPLIT_LEARN = 8'hff;

  typedef enum logic [3:0] {
    MSG_NOTE_OFF      = 4'h8,
    MSG_NOTE_ON       = 4'h9,
    MSG_POLY_PRESSURE = 4'ha
  } msg_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNEL      = 3'd0,
    REG_ZONE1_CHANNEL   = 3'd1,
    REG_ZONE2_CHANNEL   = 3'd2,
    REG_SPLIT_NOTE      = 3'd3,
    REG_ZONE1_TRANSPOSE = 3'd4,
    REG_ZONE2_TRANSPOSE = 3'd5
  } cfg_reg_t;

  localparam logic [CHAN_W-1:0]  IN_CHANNEL_RST      = 4'd0;
  localparam logic [ZCH_W-1:0]   ZONE1_CHANNEL_RST   = 5'd0;
  localparam logic [ZCH_W-1:0]   ZONE2_CHANNEL_RST   = 5'd1;
  localparam logic [SPLIT_W-1:0] SPLIT_NOTE_RST      = 8'd60;
  localparam logic [XPOS_W-1:0]  ZONE1_TRANSPOSE_RST = 7'd0;
  localparam logic [XPOS_W-1:0]  ZONE2_TRANSPOSE_RST = 7'd0;

  // Add a signed transpose to a key and clamp to the note range.
  function automatic logic [NOTE_W-1:0] clamp_note(input logic [NOTE_W-1:0] key,
                                                    input logic [XPOS_W-1:0] xpos);
    logic [NOTE_W+1:0] sum;
    sum = {2'b00, key} + {{(NOTE_W+2-XPOS_W){xpos[XPOS_W-1]}}, xpos};
    if (sum[NOTE_W+1]) begin
      clamp_note = '0;
    end else if (sum[NOTE_W]) begin
      clamp_note = NOTE_MAX;
    end else begin
      clamp_note = sum[NOTE_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/midi_key_split_transpose.sv -----
// MIDI keyboard split with per-zone output channel and transpose.
//
// Requests on the in_ channel carry one three-byte MIDI message each; every
// request yields exactly one message on the out_ channel, in order.
// Note-on, note-off and poly pressure on the configured input channel are
// routed to zone 1 or zone 2 by the split key and remapped; all else passes.
// The input accept loads stage one; the stage-one advance loads the output
// register that drives out_valid. Throughput is one request per cycle while
// the receiver does not stall: stage one holds the message and its per-key
// transpose read from the RAM; on its advance the result is computed, the RAM
// written back and the output register filled. A write-back hitting the key
// read in the same cycle is forwarded. When the receiver stalls, the output
// register holds, stage one fills, and in_ready drops only when both are full.
// Reset clears all per-key valid flags at once, drops any learned split and
// loads register defaults; the block accepts requests right after reset.
// cfg_ready is always high; write configuration only while the block is idle.
module midi_key_split_transpose #(
  parameter int KEY_COUNT = mkst_pkg::KEY_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mkst_pkg::BYTE_W-1:0]     in_status_byte,
  input  logic [mkst_pkg::BYTE_W-1:0]     in_first_data,
  input  logic [mkst_pkg::BYTE_W-1:0]     in_second_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mkst_pkg::BYTE_W-1:0]     out_status,
  output logic [mkst_pkg::BYTE_W-1:0]     out_first,
  output logic [mkst_pkg::BYTE_W-1:0]     out_second,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mkst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkst_pkg::BYTE_W-1:0]     cfg_data
);

  import mkst_pkg::*;

  localparam int KEY_W = $clog2(KEY_COUNT);

  logic [CHAN_W-1:0]  in_channel_r;
  logic [ZCH_W-1:0]   zone1_channel_r;
  logic [ZCH_W-1:0]   zone2_channel_r;
  logic [SPLIT_W-1:0] split_note_r;
  logic [XPOS_W-1:0]  zone1_transpose_r;
  logic [XPOS_W-1:0]  zone2_transpose_r;
  logic               learned_vld_r;
  logic [NOTE_W-1:0]  learned_split_r;

  logic [KEY_COUNT-1:0] key_vld_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_status_r;
  logic [BYTE_W-1:0] s1_first_r;
  logic [BYTE_W-1:0] s1_second_r;
  logic              fwd_hit_r;
  logic [XPOS_W-1:0] fwd_val_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_status_r;
  logic [BYTE_W-1:0] out_first_r;
  logic [BYTE_W-1:0] out_second_r;

  logic              in_fire;
  logic              s1_adv;
  logic [XPOS_W-1:0] ram_rd_data;

  logic [3:0]         s1_type;
  logic [CHAN_W-1:0]  s1_chan;
  logic [NOTE_W-1:0]  s1_key;
  logic [KEY_W-1:0]   s1_addr;
  logic               s1_note_on;
  logic               s1_note_off;
  logic               s1_poly;
  logic               s1_remap;
  logic [SPLIT_W-1:0] s1_split;
  logic               s1_zone1;
  logic [ZCH_W-1:0]   s1_zch;
  logic [XPOS_W-1:0]  s1_ztr;
  logic [CHAN_W-1:0]  s1_och;
  logic [XPOS_W-1:0]  s1_stored;
  logic               s1_entry_vld;
  logic               s1_wr_en;
  logic [3:0]         s1_type_norm;
  logic [BYTE_W-1:0]  out_status_nxt;
  logic [BYTE_W-1:0]  out_first_nxt;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;

  // Decode and remap the message held in stage one.
  always_comb begin
    s1_type      = s1_status_r[7:4];
    s1_chan      = s1_status_r[3:0];
    s1_key       = s1_first_r[NOTE_W-1:0];
    s1_addr      = s1_first_r[KEY_W-1:0];
    s1_note_on   = (s1_type == MSG_NOTE_ON) && (s1_second_r[NOTE_W-1:0] != '0);
    s1_note_off  = (s1_type == MSG_NOTE_OFF) ||
                   ((s1_type == MSG_NOTE_ON) && (s1_second_r[NOTE_W-1:0] == '0));
    s1_poly      = (s1_type == MSG_POLY_PRESSURE);
    s1_remap     = (s1_chan == in_channel_r) && (s1_note_on || s1_note_off || s1_poly);
    s1_split     = learned_vld_r ? {1'b0, learned_split_r} : split_note_r;
    s1_zone1     = $signed({1'b0, s1_key}) < $signed(s1_split);
    s1_zch       = s1_zone1 ? zone1_channel_r : zone2_channel_r;
    s1_ztr       = s1_zone1 ? zone1_transpose_r : zone2_transpose_r;
    s1_och       = s1_zch[ZCH_W-1] ? s1_chan : s1_zch[CHAN_W-1:0];
    s1_stored    = fwd_hit_r ? fwd_val_r : ram_rd_data;
    s1_entry_vld = key_vld_r[s1_addr];
    s1_wr_en     = s1_adv && s1_remap && s1_note_on;
    s1_type_norm = s1_note_off ? MSG_NOTE_OFF : s1_type;

    out_status_nxt = s1_status_r;
    out_first_nxt  = s1_first_r;
    if (s1_remap) begin
      out_status_nxt = {s1_type_norm, s1_och};
      if (s1_note_off) begin
        out_first_nxt = s1_entry_vld ? {1'b0, clamp_note(s1_key, s1_stored)} : '0;
      end else begin
        out_first_nxt = {1'b0, clamp_note(s1_key, s1_ztr)};
      end
    end
  end

  mkst_ram #(
    .WIDTH (XPOS_W),
    .DEPTH (KEY_COUNT)
  ) u_xpos_ram (
    .clk     (clk),
    .wr_en   (s1_wr_en),
    .wr_addr (s1_addr),
    .wr_data (s1_ztr),
    .rd_en   (in_fire),
    .rd_addr (in_first_data[KEY_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_channel_r      <= IN_CHANNEL_RST;
      zone1_channel_r   <= ZONE1_CHANNEL_RST;
      zone2_channel_r   <= ZONE2_CHANNEL_RST;
      split_note_r      <= SPLIT_NOTE_RST;
      zone1_transpose_r <= ZONE1_TRANSPOSE_RST;
      zone2_transpose_r <= ZONE2_TRANSPOSE_RST;
      learned_vld_r     <= 1'b0;
      learned_split_r   <= '0;
      key_vld_r         <= '0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      fwd_hit_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IN_CHANNEL:      in_channel_r      <= cfg_data[CHAN_W-1:0];
          REG_ZONE1_CHANNEL:   zone1_channel_r   <= cfg_data[ZCH_W-1:0];
          REG_ZONE2_CHANNEL:   zone2_channel_r   <= cfg_data[ZCH_W-1:0];
          REG_SPLIT_NOTE: begin
            split_note_r  <= cfg_data[SPLIT_W-1:0];
            learned_vld_r <= 1'b0;
          end
          REG_ZONE1_TRANSPOSE: zone1_transpose_r <= cfg_data[XPOS_W-1:0];
          REG_ZONE2_TRANSPOSE: zone2_transpose_r <= cfg_data[XPOS_W-1:0];
          default: ;
        endcase
      end

      if (s1_adv && s1_remap) begin
        if (s1_note_on) begin
          key_vld_r[s1_addr] <= 1'b1;
          if (!learned_vld_r && (split_note_r == SPLIT_LEARN)) begin
            learned_vld_r   <= 1'b1;
            learned_split_r <= s1_key;
          end
        end else if (s1_note_off) begin
          key_vld_r[s1_addr] <= 1'b0;
        end
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_wr_en && (s1_addr == in_first_data[KEY_W-1:0]);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= in_status_byte;
      s1_first_r  <= in_first_data;
      s1_second_r <= in_second_data;
      fwd_val_r   <= s1_ztr;
    end
    if (s1_adv) begin
      out_status_r <= out_status_nxt;
      out_first_r  <= out_first_nxt;
      out_second_r <= s1_second_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_ready)
    else $error("input accepted while stage one is blocked");

  a_note_on_marks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr_en |=> key_vld_r[$past(s1_addr)])
    else $error("note-on did not mark its key entry");

  a_note_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_remap && s1_note_off |=> !key_vld_r[$past(s1_addr)])
    else $error("note-off did not clear its key entry");

  a_unheld_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_remap && s1_note_off && !s1_entry_vld |=> out_first_r == '0)
    else $error("note-off on an unheld key gave a nonzero note");

endmodule

// ----- rtl/core/mkst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
